>>> src/rlsc_pkg.sv
`default_nettype none
package rlsc_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int NUM_REGS = 4;
  localparam int MAX_MOVES = 4;
  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;
  localparam logic [1:0] REG_MIN_X = 2'd0;
  localparam logic [1:0] REG_MAX_X = 2'd1;
  localparam logic [1:0] REG_MIN_Y = 2'd2;
  localparam logic [1:0] REG_MAX_Y = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new segment
    logic setup;     // prepare the next endpoint move (operands to divider)
    logic div_start; // start the divider
    logic commit;    // write the moved endpoint back
    logic finish;    // latch the result
    logic accept;    // result flag value
  } rlsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial_acc;
    logic trivial_rej;
    logic div_done;
  } rlsc_sts_t;
endpackage
`default_nettype wire

>>> src/rlsc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, magnitudes only.
module rlsc_div #(
  parameter int NB = 34,
  parameter int DB = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NB-1:0] num,
  input  wire logic [DB-1:0] den,
  output logic               done,
  output logic [NB-1:0]      quo
);
  localparam int CW = $clog2(NB + 1);
  logic [NB-1:0] quo_r, quo_nxt;
  logic [DB-1:0] rem_r, rem_nxt;
  logic [DB-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DB:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[NB-1]};
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DB'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DB-1:0];
        quo_nxt = {quo_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

>>> src/rlsc_datapath.sv
`default_nettype none
module rlsc_datapath #(
  parameter int COORD_BITS = rlsc_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rlsc_pkg::rlsc_cmd_t           cmd,
  output rlsc_pkg::rlsc_sts_t                sts,
  input  wire logic signed [COORD_BITS-1:0]  min_x,
  input  wire logic signed [COORD_BITS-1:0]  max_x,
  input  wire logic signed [COORD_BITS-1:0]  min_y,
  input  wire logic signed [COORD_BITS-1:0]  max_y,
  input  wire logic [4*COORD_BITS-1:0]       seg_in,
  output logic                               res_acc,
  output logic [4*COORD_BITS-1:0]            res_out
);
  import rlsc_pkg::*;
  localparam int W  = COORD_BITS;
  localparam int DW = W + 1;      // differences
  localparam int PW = 2 * DW;     // products

  logic signed [W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [3:0] cs, ce;
  logic       sel_end_r;
  logic       vert_r;            // edge is horizontal line: solve for x
  logic signed [W-1:0] base_r, edge_r;
  logic       neg_r;
  logic [PW-1:0] prod_r;
  logic [DW-1:0] den_mag_r;
  logic       acc_r;
  logic [4*W-1:0] out_r;
  logic [PW-1:0] quo;
  logic       div_done;

  function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y);
    logic [3:0] c;
    c = '0;
    if (x < min_x) c = c | CODE_LEFT;
    if (x > max_x) c = c | CODE_RIGHT;
    if (y < min_y) c = c | CODE_BOTTOM;
    if (y > max_y) c = c | CODE_TOP;
    return c;
  endfunction

  assign cs = outcode(sx_r, sy_r);
  assign ce = outcode(ex_r, ey_r);
  // Fields from the top: trivial_acc, trivial_rej, div_done.
  assign sts = {((cs | ce) == 4'd0), ((cs & ce) != 4'd0), div_done};

  // Operand selection for the endpoint being moved.
  logic              use_end;
  logic [3:0]        code;
  logic signed [W-1:0] px, py, qx, qy;
  logic signed [DW-1:0] dx, dy, a, b, c;
  logic              vert;
  logic signed [W-1:0] edge_v, base_v;
  logic signed [PW-1:0] p;

  always_comb begin
    use_end = (cs == 4'd0);
    code = use_end ? ce : cs;
    px = use_end ? ex_r : sx_r;
    py = use_end ? ey_r : sy_r;
    qx = use_end ? sx_r : ex_r;
    qy = use_end ? sy_r : ey_r;
    dx = DW'(qx) - DW'(px);
    dy = DW'(qy) - DW'(py);
    vert = 1'b1;
    edge_v = max_y;
    base_v = px;
    a = dx;
    b = DW'(max_y) - DW'(py);
    c = dy;
    priority if ((code & CODE_TOP) != 4'd0) begin
      edge_v = max_y;
    end else if ((code & CODE_BOTTOM) != 4'd0) begin
      edge_v = min_y;
      b = DW'(min_y) - DW'(py);
    end else if ((code & CODE_LEFT) != 4'd0) begin
      vert = 1'b0; edge_v = min_x; base_v = py;
      a = dy; b = DW'(min_x) - DW'(px); c = dx;
    end else begin
      vert = 1'b0; edge_v = max_x; base_v = py;
      a = dy; b = DW'(max_x) - DW'(px); c = dx;
    end
    p = PW'(a) * PW'(b);
  end

  // Registered product feeds the divider; magnitudes and sign split here.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= seg_in[W-1:0];
      sy_r <= seg_in[2*W-1:W];
      ex_r <= seg_in[3*W-1:2*W];
      ey_r <= seg_in[4*W-1:3*W];
    end else if (cmd.commit) begin
      if (sel_end_r) begin
        if (vert_r) begin
          ex_r <= W'(base_r + (neg_r ? -$signed(quo[W-1:0]) : $signed(quo[W-1:0])));
          ey_r <= edge_r;
        end else begin
          ey_r <= W'(base_r + (neg_r ? -$signed(quo[W-1:0]) : $signed(quo[W-1:0])));
          ex_r <= edge_r;
        end
      end else begin
        if (vert_r) begin
          sx_r <= W'(base_r + (neg_r ? -$signed(quo[W-1:0]) : $signed(quo[W-1:0])));
          sy_r <= edge_r;
        end else begin
          sy_r <= W'(base_r + (neg_r ? -$signed(quo[W-1:0]) : $signed(quo[W-1:0])));
          sx_r <= edge_r;
        end
      end
    end
    if (cmd.setup) begin
      sel_end_r <= use_end;
      vert_r    <= vert;
      base_r    <= base_v;
      edge_r    <= edge_v;
      neg_r     <= p[PW-1] ^ c[DW-1];
      prod_r    <= p[PW-1] ? PW'(-p) : PW'(p);
      den_mag_r <= c[DW-1] ? DW'(-c) : DW'(c);
    end
    if (cmd.finish) begin
      out_r <= cmd.accept ? {ey_r, ex_r, sy_r, sx_r} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= 1'b0;
    else if (cmd.finish) acc_r <= cmd.accept;
  end

  rlsc_div #(.NB(PW), .DB(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(prod_r), .den(den_mag_r), .done(div_done), .quo(quo)
  );

  assign res_acc = acc_r;
  assign res_out = out_r;
endmodule
`default_nettype wire

>>> src/rlsc_ctrl.sv
`default_nettype none
module rlsc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire logic                out_fire,
  output logic                     in_ready,
  output logic                     out_valid,
  output rlsc_pkg::rlsc_cmd_t      cmd,
  input  wire rlsc_pkg::rlsc_sts_t sts
);
  import rlsc_pkg::*;
  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_START, S_DIV, S_OUT
  } state_t;
  state_t state_r;
  logic [2:0] moves_r;
  logic       valid_r;

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    unique case (state_r)
      S_EVAL: begin
        if (sts.trivial_acc) begin
          cmd.finish = 1'b1; cmd.accept = 1'b1;
        end else if (sts.trivial_rej || moves_r == 3'(MAX_MOVES)) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.setup = 1'b1;
        end
      end
      S_START: cmd.div_start = 1'b1;
      S_DIV:   cmd.commit = sts.div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      moves_r <= '0;
      valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          state_r <= S_EVAL;
          moves_r <= '0;
        end
        S_EVAL: begin
          if (cmd.finish) begin
            state_r <= S_OUT;
            valid_r <= 1'b1;
          end else begin
            state_r <= S_START;
          end
        end
        S_START: state_r <= S_DIV;
        S_DIV: if (sts.div_done) begin
          moves_r <= moves_r + 3'd1;
          state_r <= S_EVAL;
        end
        S_OUT: if (out_fire) begin
          valid_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = valid_r;
endmodule
`default_nettype wire

>>> src/rect_line_segment_clipper_core.sv
`default_nettype none
// Cohen-Sutherland clipper: takes one segment at a time and returns one result per
// segment. A trivially accepted or rejected segment is finished without a divide;
// each endpoint move, at most four per segment, uses the shared one-bit-per-cycle
// divider.
// Registers: 0 min_x, 1 max_x, 2 min_y, 3 max_y at byte addresses 0, 4, 8, 12.
module rect_line_segment_clipper_core #(
  parameter int COORD_BITS = rlsc_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // accepted, clip_start_x, clip_start_y, clip_end_x, clip_end_y
  output logic [((4*COORD_BITS+8)/8)*8-1:0] out_tdata,
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [3:0]              cfg_paddr,
  input  wire logic [31:0]             cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import rlsc_pkg::*;
  localparam int W = COORD_BITS;
  localparam int OW = ((4*COORD_BITS+8)/8)*8;

  logic signed [W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [1:0] ridx;
  rlsc_cmd_t cmd;
  rlsc_sts_t sts;
  logic res_acc;
  logic [4*W-1:0] res_out;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0;
      max_x_r <= W'(1023);
      min_y_r <= '0;
      max_y_r <= W'(1023);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      unique case (ridx)
        REG_MIN_X: min_x_r <= cfg_pwdata[W-1:0];
        REG_MAX_X: max_x_r <= cfg_pwdata[W-1:0];
        REG_MIN_Y: min_y_r <= cfg_pwdata[W-1:0];
        REG_MAX_Y: max_y_r <= cfg_pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MIN_X: cfg_prdata = 32'(min_x_r);
      REG_MAX_X: cfg_prdata = 32'(max_x_r);
      REG_MIN_Y: cfg_prdata = 32'(min_y_r);
      REG_MAX_Y: cfg_prdata = 32'(max_y_r);
      default:   cfg_prdata = '0;
    endcase
  end

  rlsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready), .out_fire(out_tvalid && out_tready),
    .in_ready(in_tready), .out_valid(out_tvalid), .cmd(cmd), .sts(sts)
  );

  rlsc_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .min_x(min_x_r), .max_x(max_x_r), .min_y(min_y_r), .max_y(max_y_r),
    .seg_in(in_tdata[4*W-1:0]), .res_acc(res_acc), .res_out(res_out)
  );

  assign out_tdata = OW'({res_out, res_acc});
endmodule
`default_nettype wire

>>> src/rlsc_checker.sv
`default_nettype none
module rlsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);
  // A rejected result carries zero coordinates.
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> out_tdata[64:1] == 64'd0)
    else $error("rejected result with nonzero coordinates");
  // No new request while a result is pending.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");
  // An accepted request yields no result in the very next cycle's edge.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result appeared too early");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
endmodule

bind rect_line_segment_clipper_core rlsc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

>>> sim/rect_line_segment_clipper_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module rect_line_segment_clipper_core_tb;
  import rlsc_pkg::*;

  localparam int CB = 16;
  localparam int INW = ((4*CB+7)/8)*8;
  localparam int OUTW = ((4*CB+8)/8)*8;
  localparam int N_RANDOM = 1100;
  localparam int LIMIT_CYCLES = 900000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t ey;
    coord_t ex;
    coord_t sy;
    coord_t sx;
  } seg_t;
  typedef struct {
    logic   acc;
    coord_t sx, sy, ex, ey;
  } clip_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [INW-1:0] in_tdata;
  logic [OUTW-1:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  rect_line_segment_clipper_core #(.COORD_BITS(CB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  longint win_lx, win_hx, win_ly, win_hy;
  clip_t  clip_q[$];
  int     errors;
  int     cycles;
  bit     calm;       // no idling in the last part of the run
  bit     long_hold;  // receiver holds off for a long stretch

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [3:0] region(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < win_lx) c |= CODE_LEFT;
    if (x > win_hx) c |= CODE_RIGHT;
    if (y < win_ly) c |= CODE_BOTTOM;
    if (y > win_hy) c |= CODE_TOP;
    return c;
  endfunction

  // Truncating a*b/c; the operands are small enough for 64-bit products.
  function automatic longint scale(longint a, longint b, longint c);
    longint p;
    p = a * b;
    if (c == 0) return 0;
    return p / c;
  endfunction

  function automatic void move_onto_edge(ref longint px, ref longint py,
                                         input longint qx, input longint qy,
                                         input logic [3:0] c);
    longint dx, dy;
    dx = qx - px;
    dy = qy - py;
    if (c & CODE_TOP) begin
      px = px + scale(dx, win_hy - py, dy);
      py = win_hy;
    end else if (c & CODE_BOTTOM) begin
      px = px + scale(dx, win_ly - py, dy);
      py = win_ly;
    end else if (c & CODE_LEFT) begin
      py = py + scale(dy, win_lx - px, dx);
      px = win_lx;
    end else if (c & CODE_RIGHT) begin
      py = py + scale(dy, win_hx - px, dx);
      px = win_hx;
    end
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    longint sx, sy, ex, ey;
    logic [3:0] cs, ce;
    int moves;
    clip_t r;
    sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
    cs = region(sx, sy);
    ce = region(ex, ey);
    moves = 0;
    r = '{acc: 1'b0, sx: '0, sy: '0, ex: '0, ey: '0};
    forever begin
      if ((cs | ce) == 0) begin
        r = '{acc: 1'b1, sx: coord_t'(sx), sy: coord_t'(sy),
              ex: coord_t'(ex), ey: coord_t'(ey)};
        break;
      end
      if ((cs & ce) != 0 || moves >= MAX_MOVES) break;
      if (cs != 0) begin
        move_onto_edge(sx, sy, ex, ey, cs);
        cs = region(sx, sy);
      end else begin
        move_onto_edge(ex, ey, sx, sy, ce);
        ce = region(ex, ey);
      end
      moves++;
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, coord_t v);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {{(32-CB){v[CB-1]}}, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_MIN_X: win_lx = v;
      REG_MAX_X: win_hx = v;
      REG_MIN_Y: win_ly = v;
      default:   win_hy = v;
    endcase
  endtask

  // Drop the request line once the last segment of a run has been taken.
  task automatic stop_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic set_window(coord_t lx, coord_t hx, coord_t ly, coord_t hy);
    stop_input();
    while (clip_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    write_reg(REG_MIN_X, lx);
    write_reg(REG_MAX_X, hx);
    write_reg(REG_MIN_Y, ly);
    write_reg(REG_MAX_Y, hy);
  endtask

  // Offer one segment; the expectation is queued when the request is taken.
  task automatic send_segment(seg_t s, bit has_fixed, clip_t fixed);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    clip_q.push_back(has_fixed ? fixed : clip_segment(s));
  endtask

  function automatic coord_t near_edge(longint lo, longint hi);
    longint v;
    case ($urandom_range(0, 5))
      0: v = $signed(16'($urandom));
      1: v = lo + $signed(7'($urandom));
      2: v = hi + $signed(7'($urandom));
      default: v = lo + longint'($urandom_range(0, 1000)) * (hi - lo) / 1000
                   + $signed(5'($urandom));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  function automatic seg_t random_segment();
    seg_t s;
    s.sx = near_edge(win_lx, win_hx);
    s.sy = near_edge(win_ly, win_hy);
    s.ex = near_edge(win_lx, win_hx);
    s.ey = near_edge(win_ly, win_hy);
    return s;
  endfunction

  // Receiver: random stalls, plus one long hold-off to fill the block.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (long_hold) out_tready <= 1'b0;
    else if (!calm && $urandom_range(0, 4) == 0) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    clip_t want;
    logic  got_acc;
    coord_t gsx, gsy, gex, gey;
    if (rst_n && out_tvalid && out_tready) begin
      got_acc = out_tdata[0];
      gsx = out_tdata[1 +: CB];
      gsy = out_tdata[1+CB +: CB];
      gex = out_tdata[1+2*CB +: CB];
      gey = out_tdata[1+3*CB +: CB];
      if (clip_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = clip_q.pop_front();
        if (got_acc !== want.acc || gsx !== want.sx || gsy !== want.sy ||
            gex !== want.ex || gey !== want.ey) begin
          $display("%0t mismatch: expected acc=%0d (%0d,%0d)-(%0d,%0d) got acc=%0d (%0d,%0d)-(%0d,%0d)",
                   $time, want.acc, want.sx, want.sy, want.ex, want.ey,
                   got_acc, gsx, gsy, gex, gey);
          errors++;
        end
      end
    end
  end

  typedef struct {
    seg_t  s;
    bit    fixed;
    clip_t r;
  } row_t;

  initial begin
    row_t rows[$];
    int k;
    clip_t rej;
    rej = '{acc: 1'b0, sx: '0, sy: '0, ex: '0, ey: '0};
    errors = 0; cycles = 0; calm = 0; long_hold = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    win_lx = 0; win_hx = 1023; win_ly = 0; win_hy = 1023;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part against the reset window.
    rows.push_back('{'{sx: 0, sy: 0, ex: 1023, ey: 1023}, 1,
                     '{1'b1, 16'sd0, 16'sd0, 16'sd1023, 16'sd1023}});
    rows.push_back('{'{sx: 10, sy: 20, ex: 30, ey: 40}, 1,
                     '{1'b1, 16'sd10, 16'sd20, 16'sd30, 16'sd40}});
    rows.push_back('{'{sx: -32768, sy: -32768, ex: -5, ey: -32768}, 1, rej});
    rows.push_back('{'{sx: 32767, sy: 32767, ex: 2000, ey: 32767}, 1, rej});
    rows.push_back('{'{sx: -32768, sy: 500, ex: -1, ey: 600}, 1, rej});
    rows.push_back('{'{sx: 1024, sy: 0, ex: 32767, ey: 1023}, 1, rej});
    rows.push_back('{'{sx: -100, sy: 500, ex: 2000, ey: 500}, 0, rej});
    rows.push_back('{'{sx: 500, sy: 32767, ex: 500, ey: -32768}, 0, rej});
    rows.push_back('{'{sx: -32768, sy: -32768, ex: 32767, ey: 32767}, 0, rej});
    rows.push_back('{'{sx: 32767, sy: -32768, ex: -32768, ey: 32767}, 0, rej});
    rows.push_back('{'{sx: -50, sy: 1100, ex: 1100, ey: -50}, 0, rej});
    rows.push_back('{'{sx: -10, sy: 1040, ex: 40, ey: 1060}, 0, rej});
    rows.push_back('{'{sx: -600, sy: 400, ex: 400, ey: -600}, 0, rej});
    rows.push_back('{'{sx: 1023, sy: 1024, ex: 1024, ey: 1023}, 0, rej});
    foreach (rows[i]) send_segment(rows[i].s, rows[i].fixed, rows[i].r);

    // Inverted and degenerate windows.
    set_window(16'sd100, -16'sd100, 16'sd50, -16'sd50);
    for (k = 0; k < 12; k++) send_segment(random_segment(), 0, rej);
    set_window(16'sd7, 16'sd7, 16'sd7, 16'sd7);
    send_segment('{sx: 7, sy: 7, ex: 7, ey: 7}, 1, '{1'b1, 16'sd7, 16'sd7, 16'sd7, 16'sd7});
    for (k = 0; k < 12; k++) send_segment(random_segment(), 0, rej);

    // Long receiver hold-off while segments keep coming.
    set_window(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    fork
      begin
        long_hold = 1;
        repeat (1500) @(posedge clk);
        long_hold = 0;
      end
      begin
        for (k = 0; k < 20; k++) send_segment(random_segment(), 0, rej);
        stop_input();
      end
    join

    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 150 == 0) begin
        set_window(coord_t'($urandom_range(0, 65535) - 32768) >>> $urandom_range(0, 8),
                   coord_t'($urandom_range(0, 32767)) >>> $urandom_range(0, 8),
                   coord_t'($urandom_range(0, 65535) - 32768) >>> $urandom_range(0, 8),
                   coord_t'($urandom_range(0, 32767)) >>> $urandom_range(0, 8));
      end
      if (k > N_RANDOM - 100) calm = 1;
      send_segment(random_segment(), 0, rej);
    end
    stop_input();

    while (clip_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
src/rlsc_pkg.sv
src/rlsc_div.sv
src/rlsc_datapath.sv
src/rlsc_ctrl.sv
src/rect_line_segment_clipper_core.sv
src/rlsc_checker.sv
sim/rect_line_segment_clipper_core_tb.sv
